/* hw/rtl/clpg_pkg.sv */
package clpg_pkg;

   // coordinate and field widths
   localparam int CoordBits   = 16;
   localparam int ErrBits     = CoordBits + 2;
   localparam int DimBits     = 16;
   localparam int CmpBits     = (CoordBits > DimBits) ? CoordBits : DimBits;
   localparam int AddrBits    = 48;
   localparam int WordBits    = 32;
   localparam int ColorBits   = 24;
   localparam int ByteBits    = 8;
   localparam int PitchBits   = 18;
   localparam int WordsBits   = PitchBits - 2;
   localparam int ProdBits    = CoordBits + WordsBits;
   localparam int ShiftBits   = 5;

   // configuration port
   localparam int CsrIndexBits = 3;
   localparam int CsrDataBits  = AddrBits;

   localparam logic [CsrIndexBits-1:0] CsrBaseAddress  = 3'd0;
   localparam logic [CsrIndexBits-1:0] CsrScreenWidth  = 3'd1;
   localparam logic [CsrIndexBits-1:0] CsrScreenHeight = 3'd2;
   localparam logic [CsrIndexBits-1:0] CsrPitchBytes   = 3'd3;
   localparam logic [CsrIndexBits-1:0] CsrRedShift     = 3'd4;
   localparam logic [CsrIndexBits-1:0] CsrGreenShift   = 3'd5;
   localparam logic [CsrIndexBits-1:0] CsrBlueShift    = 3'd6;
   localparam logic [CsrIndexBits-1:0] CsrDisplayReady = 3'd7;

   // command codes
   localparam logic OpStart = 1'b0;
   localparam logic OpStep  = 1'b1;

   // command queue between front and walker
   localparam int QueueDepth     = 2;
   localparam int QueuePtrBits   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QueueCountBits = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic [AddrBits-1:0]  base_address;
      logic [DimBits-1:0]   screen_width;
      logic [DimBits-1:0]   screen_height;
      logic [PitchBits-1:0] pitch_bytes;
      logic [ShiftBits-1:0] red_shift;
      logic [ShiftBits-1:0] green_shift;
      logic [ShiftBits-1:0] blue_shift;
      logic                 display_ready;
   } csr_type;

   typedef struct packed {
      logic                 op;
      logic [CoordBits-1:0] x_begin;
      logic [CoordBits-1:0] y_begin;
      logic [CoordBits-1:0] x_finish;
      logic [CoordBits-1:0] y_finish;
      logic [CoordBits-1:0] delta_x;
      logic [CoordBits-1:0] delta_y;
      logic                 x_neg;
      logic                 y_neg;
      logic [WordBits-1:0]  color;
   } cmd_type;

   typedef struct packed {
      logic [CoordBits-1:0] x;
      logic [CoordBits-1:0] y;
      logic [WordBits-1:0]  color;
      logic                 write_enable;
      logic                 last_pixel;
   } pix_type;

   // place the three colour bytes at their configured shifts
   function automatic logic [WordBits-1:0] pack_color(input logic [ColorBits-1:0] rgb,
                                                      input csr_type csr);
      logic [WordBits-1:0] r;
      logic [WordBits-1:0] g;
      logic [WordBits-1:0] b;
      r = WordBits'(rgb[3*ByteBits-1:2*ByteBits]);
      g = WordBits'(rgb[2*ByteBits-1:ByteBits]);
      b = WordBits'(rgb[ByteBits-1:0]);
      return (r << csr.red_shift) | (g << csr.green_shift) | (b << csr.blue_shift);
   endfunction

endpackage

/* hw/rtl/clpg_req_if.sv */
interface clpg_req_if import clpg_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 op;
   logic [CoordBits-1:0] x_begin;
   logic [CoordBits-1:0] y_begin;
   logic [CoordBits-1:0] x_finish;
   logic [CoordBits-1:0] y_finish;
   logic [ColorBits-1:0] color_rgb;

   modport source (output valid, op, x_begin, y_begin, x_finish, y_finish, color_rgb,
                   input ready);
   modport sink (input valid, op, x_begin, y_begin, x_finish, y_finish, color_rgb,
                 output ready);
endinterface

/* hw/rtl/clpg_rsp_if.sv */
interface clpg_rsp_if import clpg_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [AddrBits-1:0] pixel_address;
   logic [WordBits-1:0] pixel_word;
   logic                write_enable;
   logic                last_pixel;

   modport source (output valid, pixel_address, pixel_word, write_enable, last_pixel,
                   input ready);
   modport sink (input valid, pixel_address, pixel_word, write_enable, last_pixel,
                 output ready);
endinterface

/* hw/rtl/clipped_line_pixel_generator_core.sv */
// Bresenham line engine producing one frame-memory pixel write per step.
// req_chan (valid/ready) takes command words: op start loads both endpoints
// and the colour, op step asks for the next pixel of the running line.
// rsp_chan (valid/ready) gives byte address, packed pixel word, write enable
// (clear when the point is off screen or the display is not ready) and a
// last flag on the endpoint, after which the engine is idle.
// csr_*: write enable, register index and data; the user must write registers
// only while the engine has no words in flight; the block does not enforce it.
// Throughput: one word per cycle on both channels while the receiver does not
// stall; the walker's error update is a subtract, an add and two compares.
// A step passes through the queue, the walker, the row multiply, and the
// address add and output register before its pixel shows on rsp_chan.
// Starts and idle steps give no pixel; starts are dropped while not ready.
// Reset (synchronous) clears the registers to zero, empties the queue and
// leaves the engine idle. When the receiver stalls, the walker and address
// stages hold, and the two-entry queue keeps taking words until full.
module clipped_line_pixel_generator_core import clpg_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   clpg_req_if.sink                req_chan,
   clpg_rsp_if.source              rsp_chan,
   input  logic                    csr_write_enable,
   input  logic [CsrIndexBits-1:0] csr_index,
   input  logic [CsrDataBits-1:0]  csr_write_data
);

   csr_type csr_ff, csr_in;
   logic    q_valid;
   cmd_type q_cmd;
   logic    q_pop;
   logic    advance;
   logic    pix_valid;
   pix_type pix;

   // register writes
   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CsrBaseAddress:  csr_in.base_address  = csr_write_data[AddrBits-1:0];
            CsrScreenWidth:  csr_in.screen_width  = csr_write_data[DimBits-1:0];
            CsrScreenHeight: csr_in.screen_height = csr_write_data[DimBits-1:0];
            CsrPitchBytes:   csr_in.pitch_bytes   = csr_write_data[PitchBits-1:0];
            CsrRedShift:     csr_in.red_shift     = csr_write_data[ShiftBits-1:0];
            CsrGreenShift:   csr_in.green_shift   = csr_write_data[ShiftBits-1:0];
            CsrBlueShift:    csr_in.blue_shift    = csr_write_data[ShiftBits-1:0];
            CsrDisplayReady: csr_in.display_ready = csr_write_data[0];
            default:         csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // command intake and queue
   clpg_front u_front (
      .clock   (clock),
      .reset   (reset),
      .csr     (csr_ff),
      .req     (req_chan),
      .q_valid (q_valid),
      .q_cmd   (q_cmd),
      .q_pop   (q_pop)
   );

   // error walk
   clpg_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .advance   (advance),
      .pix_valid (pix_valid),
      .pix       (pix)
   );

   // address generation and output register
   clpg_addr u_addr (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .pix_valid (pix_valid),
      .pix       (pix),
      .advance   (advance),
      .rsp       (rsp_chan)
   );

`ifndef SYNTHESIS
   // a full queue always has a word to offer the walker
   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> q_valid)
      else $error("queue full but empty");

   // the walker never takes from an empty queue
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");

   // a start never produces a pixel
   a_start_silent: assert property (@(posedge clock) disable iff (reset)
      (q_pop && (q_cmd.op == OpStart)) |=> !pix_valid)
      else $error("pixel produced by a start word");
`endif

endmodule

/* hw/rtl/clpg_front.sv */
module clpg_front import clpg_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  csr_type csr,
   clpg_req_if.sink req,
   output logic    q_valid,
   output cmd_type q_cmd,
   input  logic    q_pop
);

   cmd_type                   q_mem_ff [QueueDepth];
   logic [QueuePtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCountBits-1:0] count_ff, count_in;
   logic                      push;
   cmd_type                   cmd;

   // room in the queue decides acceptance
   assign req.ready = (count_ff != QueueCountBits'(QueueDepth));

   // starts are dropped here while the display is not ready
   assign push = req.valid && req.ready && ((req.op == OpStep) || csr.display_ready);

   // classify the word: line direction, magnitudes and packed colour
   always_comb begin
      cmd.op       = req.op;
      cmd.x_begin  = req.x_begin;
      cmd.y_begin  = req.y_begin;
      cmd.x_finish = req.x_finish;
      cmd.y_finish = req.y_finish;
      cmd.x_neg    = req.x_finish < req.x_begin;
      cmd.y_neg    = req.y_finish < req.y_begin;
      cmd.delta_x  = cmd.x_neg ? (req.x_begin - req.x_finish) : (req.x_finish - req.x_begin);
      cmd.delta_y  = cmd.y_neg ? (req.y_begin - req.y_finish) : (req.y_finish - req.y_begin);
      cmd.color    = pack_color(req.color_rgb, csr);
   end

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= cmd;
      end
   end

   assign q_valid = (count_ff != '0);
   assign q_cmd   = q_mem_ff[rd_ptr_ff];

endmodule

/* hw/rtl/clpg_walker.sv */
module clpg_walker import clpg_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  csr_type csr,
   input  logic    q_valid,
   input  cmd_type q_cmd,
   output logic    q_pop,
   input  logic    advance,
   output logic    pix_valid,
   output pix_type pix
);

   logic                        busy_ff, busy_in;
   logic [CoordBits-1:0]        cur_x_ff, cur_x_in;
   logic [CoordBits-1:0]        cur_y_ff, cur_y_in;
   logic [CoordBits-1:0]        tgt_x_ff, tgt_x_in;
   logic [CoordBits-1:0]        tgt_y_ff, tgt_y_in;
   logic [CoordBits-1:0]        dx_ff, dx_in;
   logic [CoordBits-1:0]        dy_ff, dy_in;
   logic                        x_neg_ff, x_neg_in;
   logic                        y_neg_ff, y_neg_in;
   logic signed [ErrBits-1:0]   err_ff, err_in;
   logic [WordBits-1:0]         color_ff, color_in;
   logic                        pix_valid_ff, pix_valid_in;
   pix_type                     pix_ff, pix_in;
   logic signed [ErrBits:0]     e2, dx_wide, dy_wide;
   logic signed [ErrBits-1:0]   dx_err, dy_err;
   logic                        move_x, move_y, at_end, on_screen, is_step;

   assign q_pop   = q_valid && advance;
   assign is_step = q_pop && (q_cmd.op == OpStep) && busy_ff;

   // error walk decisions
   always_comb begin
      dx_err    = $signed(ErrBits'(dx_ff));
      dy_err    = $signed(ErrBits'(dy_ff));
      dx_wide   = $signed((ErrBits + 1)'(dx_ff));
      dy_wide   = $signed((ErrBits + 1)'(dy_ff));
      e2        = {err_ff, 1'b0};
      move_x    = e2 > -dy_wide;
      move_y    = e2 < dx_wide;
      at_end    = (cur_x_ff == tgt_x_ff) && (cur_y_ff == tgt_y_ff);
      on_screen = (CmpBits'(cur_x_ff) < CmpBits'(csr.screen_width)) &&
                  (CmpBits'(cur_y_ff) < CmpBits'(csr.screen_height));
   end

   // line state update
   always_comb begin
      busy_in  = busy_ff;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      tgt_x_in = tgt_x_ff;
      tgt_y_in = tgt_y_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      x_neg_in = x_neg_ff;
      y_neg_in = y_neg_ff;
      err_in   = err_ff;
      color_in = color_ff;
      if (q_pop && (q_cmd.op == OpStart)) begin
         busy_in  = 1'b1;
         cur_x_in = q_cmd.x_begin;
         cur_y_in = q_cmd.y_begin;
         tgt_x_in = q_cmd.x_finish;
         tgt_y_in = q_cmd.y_finish;
         dx_in    = q_cmd.delta_x;
         dy_in    = q_cmd.delta_y;
         x_neg_in = q_cmd.x_neg;
         y_neg_in = q_cmd.y_neg;
         err_in   = $signed(ErrBits'(q_cmd.delta_x)) - $signed(ErrBits'(q_cmd.delta_y));
         color_in = q_cmd.color;
      end else if (is_step) begin
         if (at_end) begin
            busy_in = 1'b0;
         end else begin
            err_in = err_ff - (move_x ? dy_err : '0) + (move_y ? dx_err : '0);
            if (move_x) begin
               cur_x_in = x_neg_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
            end
            if (move_y) begin
               cur_y_in = y_neg_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
            end
         end
      end
   end

   // pixel for the address stage
   always_comb begin
      pix_valid_in        = is_step;
      pix_in.x            = cur_x_ff;
      pix_in.y            = cur_y_ff;
      pix_in.color        = color_ff;
      pix_in.write_enable = on_screen && csr.display_ready;
      pix_in.last_pixel   = at_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pix_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (advance) begin
            pix_valid_ff <= pix_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      tgt_x_ff <= tgt_x_in;
      tgt_y_ff <= tgt_y_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      x_neg_ff <= x_neg_in;
      y_neg_ff <= y_neg_in;
      err_ff   <= err_in;
      color_ff <= color_in;
      if (advance) begin
         pix_ff <= pix_in;
      end
   end

   assign pix_valid = pix_valid_ff;
   assign pix       = pix_ff;

endmodule

/* hw/rtl/clpg_addr.sv */
module clpg_addr import clpg_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  csr_type csr,
   input  logic    pix_valid,
   input  pix_type pix,
   output logic    advance,
   clpg_rsp_if.source rsp
);

   logic                 s1_valid_ff;
   logic [ProdBits-1:0]  s1_prod_ff, s1_prod_in;
   pix_type              s1_pix_ff;
   logic [ProdBits:0]    idx;
   logic                 rsp_valid_ff;
   logic [AddrBits-1:0]  addr_ff, addr_in;
   logic [WordBits-1:0]  word_ff;
   logic                 we_ff;
   logic                 last_ff;

   // whole back end holds while a finished word waits
   assign advance = !(rsp_valid_ff && !rsp.ready);

   // row offset in words
   assign s1_prod_in = ProdBits'(pix.y) * ProdBits'(csr.pitch_bytes[PitchBits-1:2]);

   // word index to byte address
   always_comb begin
      idx     = (ProdBits + 1)'(s1_prod_ff) + (ProdBits + 1)'(s1_pix_ff.x);
      addr_in = csr.base_address + AddrBits'({idx, 2'b00});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= pix_valid;
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_prod_ff <= s1_prod_in;
         s1_pix_ff  <= pix;
         addr_ff    <= addr_in;
         word_ff    <= s1_pix_ff.color;
         we_ff      <= s1_pix_ff.write_enable;
         last_ff    <= s1_pix_ff.last_pixel;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.pixel_address = addr_ff;
   assign rsp.pixel_word    = word_ff;
   assign rsp.write_enable  = we_ff;
   assign rsp.last_pixel    = last_ff;

endmodule

/* tb/clipped_line_pixel_generator_core_tb.sv */
`timescale 1ns / 100ps

module clipped_line_pixel_generator_core_tb;
   import clpg_pkg::*;

   typedef struct packed {
      logic                 op;
      logic [CoordBits-1:0] x_begin;
      logic [CoordBits-1:0] y_begin;
      logic [CoordBits-1:0] x_finish;
      logic [CoordBits-1:0] y_finish;
      logic [ColorBits-1:0] color_rgb;
   } line_cmd_type;

   typedef struct packed {
      logic [AddrBits-1:0] address;
      logic [WordBits-1:0] word;
      logic                write_en;
      logic                last;
   } pixel_type;

   typedef struct {
      logic [AddrBits-1:0]  base;
      logic [DimBits-1:0]   width;
      logic [DimBits-1:0]   height;
      logic [PitchBits-1:0] pitch;
      logic [ShiftBits-1:0] red_sh;
      logic [ShiftBits-1:0] green_sh;
      logic [ShiftBits-1:0] blue_sh;
      logic                 on;
   } screen_setup_type;

   typedef enum {SetupRandom, SetupTop, SetupFloor} setup_style_type;
   typedef enum {RxAlways, RxCoin, RxMostly, RxSparse} rx_mode_type;

   // line walker prediction and the pixels still owed by the engine
   class line_walk_predictor;
      logic [AddrBits-1:0]       base_addr;
      logic [DimBits-1:0]        scr_width;
      logic [DimBits-1:0]        scr_height;
      logic [PitchBits-1:0]      pitch;
      logic [ShiftBits-1:0]      red_sh;
      logic [ShiftBits-1:0]      green_sh;
      logic [ShiftBits-1:0]      blue_sh;
      logic                      disp_on;
      logic                      busy;
      logic [CoordBits-1:0]      cur_x;
      logic [CoordBits-1:0]      cur_y;
      logic [CoordBits-1:0]      end_x;
      logic [CoordBits-1:0]      end_y;
      logic [CoordBits-1:0]      dx;
      logic [CoordBits-1:0]      dy;
      logic                      x_neg;
      logic                      y_neg;
      logic signed [ErrBits-1:0] err;
      logic [WordBits-1:0]       color;
      pixel_type                 expected_pixels[$];
      int errors;
      int lines_loaded;
      int starts_dropped;
      int idle_steps;
      int pixels_seen;
      int clipped_seen;
      int ends_seen;

      function new();
         base_addr = '0;
         scr_width = '0;
         scr_height = '0;
         pitch = '0;
         red_sh = '0;
         green_sh = '0;
         blue_sh = '0;
         disp_on = 1'b0;
         busy = 1'b0;
         cur_x = '0;
         cur_y = '0;
         end_x = '0;
         end_y = '0;
         dx = '0;
         dy = '0;
         x_neg = 1'b0;
         y_neg = 1'b0;
         err = '0;
         color = '0;
      endfunction

      function void write_reg(input logic [CsrIndexBits-1:0] idx,
                              input logic [CsrDataBits-1:0] data);
         case (idx)
            CsrBaseAddress:  base_addr = data[AddrBits-1:0];
            CsrScreenWidth:  scr_width = data[DimBits-1:0];
            CsrScreenHeight: scr_height = data[DimBits-1:0];
            CsrPitchBytes:   pitch = data[PitchBits-1:0];
            CsrRedShift:     red_sh = data[ShiftBits-1:0];
            CsrGreenShift:   green_sh = data[ShiftBits-1:0];
            CsrBlueShift:    blue_sh = data[ShiftBits-1:0];
            CsrDisplayReady: disp_on = data[0];
         endcase
      endfunction

      // each colour byte lands at its shift, overflow past bit 31 is dropped
      function logic [WordBits-1:0] place_channels(input logic [ColorBits-1:0] rgb);
         logic [WordBits-1:0] packed_word;
         packed_word = WordBits'(rgb[23:16]) << red_sh;
         packed_word |= WordBits'(rgb[15:8]) << green_sh;
         packed_word |= WordBits'(rgb[7:0]) << blue_sh;
         return packed_word;
      endfunction

      function void take_word(input line_cmd_type w);
         logic        on_screen;
         logic        at_end;
         longint      e2;
         logic [63:0] word_index;
         pixel_type   px;
         if (w.op == OpStart) begin
            if (!disp_on) begin
               starts_dropped++;
               return;
            end
            x_neg = w.x_finish < w.x_begin;
            y_neg = w.y_finish < w.y_begin;
            dx = x_neg ? w.x_begin - w.x_finish : w.x_finish - w.x_begin;
            dy = y_neg ? w.y_begin - w.y_finish : w.y_finish - w.y_begin;
            err = $signed({2'b00, dx}) - $signed({2'b00, dy});
            cur_x = w.x_begin;
            cur_y = w.y_begin;
            end_x = w.x_finish;
            end_y = w.y_finish;
            color = place_channels(w.color_rgb);
            busy = 1'b1;
            lines_loaded++;
         end else if (!busy) begin
            idle_steps++;
         end else begin
            // pixel for the current point, then advance the error walk
            on_screen = (cur_x < scr_width) && (cur_y < scr_height);
            at_end = (cur_x == end_x) && (cur_y == end_y);
            word_index = 64'(cur_y) * 64'(pitch >> 2) + 64'(cur_x);
            px.address = AddrBits'(64'(base_addr) + (word_index << 2));
            px.word = color;
            px.write_en = on_screen & disp_on;
            px.last = at_end;
            expected_pixels.push_back(px);
            if (at_end) begin
               busy = 1'b0;
            end else begin
               e2 = 2 * longint'(err);
               if (e2 > -longint'(dy)) begin
                  err = err - $signed({2'b00, dy});
                  cur_x = x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
               end
               if (e2 < longint'(dx)) begin
                  err = err + $signed({2'b00, dx});
                  cur_y = y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
               end
            end
         end
      endfunction

      function void check_pixel(input pixel_type got);
         pixel_type want;
         if (expected_pixels.size() == 0) begin
            errors++;
            $display("%0t: pixel with none expected, address %h word %h", $time,
                     got.address, got.word);
            return;
         end
         want = expected_pixels.pop_front();
         pixels_seen++;
         if (!want.write_en) clipped_seen++;
         if (want.last) ends_seen++;
         if (got.address !== want.address) begin
            errors++;
            $display("%0t: pixel_address expected %h got %h", $time, want.address,
                     got.address);
         end
         if (got.word !== want.word) begin
            errors++;
            $display("%0t: pixel_word expected %h got %h", $time, want.word, got.word);
         end
         if (got.write_en !== want.write_en) begin
            errors++;
            $display("%0t: write_enable expected %b got %b", $time, want.write_en,
                     got.write_en);
         end
         if (got.last !== want.last) begin
            errors++;
            $display("%0t: last_pixel expected %b got %b", $time, want.last, got.last);
         end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    csr_write_enable;
   logic [CsrIndexBits-1:0] csr_index;
   logic [CsrDataBits-1:0]  csr_write_data;

   clpg_req_if req_bus();
   clpg_rsp_if rsp_bus();

   clipped_line_pixel_generator_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   line_walk_predictor walker = new();
   screen_setup_type   active_setup;
   int                 burst_left = 0;
   bit                 hold_request = 1'b0;
   int                 hold_left = 0;
   rx_mode_type        rx_mode = RxAlways;
   int                 rx_mode_left = 0;
   int                 rx_tick = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // overall time limit
   initial begin
      #4_000_000;
      $display("clipped_line_pixel_generator_core_tb: FAIL");
      $finish;
   end

   // note every accepted command word
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         walker.take_word(line_cmd_type'({req_bus.op, req_bus.x_begin, req_bus.y_begin,
                                          req_bus.x_finish, req_bus.y_finish,
                                          req_bus.color_rgb}));
   end

   // check every accepted pixel word
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         walker.check_pixel(pixel_type'({rsp_bus.pixel_address, rsp_bus.pixel_word,
                                         rsp_bus.write_enable, rsp_bus.last_pixel}));
   end

   // receiver: changing stall patterns, plus one long hold-off on request
   always @(posedge clock) begin
      rx_tick++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = 400;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(16, 200);
         end
         rx_mode_left--;
         case (rx_mode)
            RxAlways: rsp_bus.ready <= 1'b1;
            RxCoin:   rsp_bus.ready <= 1'($urandom_range(0, 1));
            RxMostly: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
            default:  rsp_bus.ready <= (rx_tick % 4 == 0);
         endcase
      end
   end

   task automatic put_reg(input logic [CsrIndexBits-1:0] idx,
                          input logic [CsrDataBits-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      walker.write_reg(idx, data);
   endtask

   // back-to-back writes of every register, enable held high throughout
   task automatic load_setup(input screen_setup_type s);
      put_reg(CsrBaseAddress, CsrDataBits'(s.base));
      put_reg(CsrScreenWidth, CsrDataBits'(s.width));
      put_reg(CsrScreenHeight, CsrDataBits'(s.height));
      put_reg(CsrPitchBytes, CsrDataBits'(s.pitch));
      put_reg(CsrRedShift, CsrDataBits'(s.red_sh));
      put_reg(CsrGreenShift, CsrDataBits'(s.green_sh));
      put_reg(CsrBlueShift, CsrDataBits'(s.blue_sh));
      put_reg(CsrDisplayReady, CsrDataBits'(s.on));
      csr_write_enable <= 1'b0;
      active_setup = s;
   endtask

   // offer one word, then either carry on or close the burst with a gap
   task automatic send_word(input line_cmd_type w);
      req_bus.valid <= 1'b1;
      req_bus.op <= w.op;
      req_bus.x_begin <= w.x_begin;
      req_bus.y_begin <= w.y_begin;
      req_bus.x_finish <= w.x_finish;
      req_bus.y_finish <= w.y_finish;
      req_bus.color_rgb <= w.color_rgb;
      do @(posedge clock); while (!req_bus.ready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(0, 8);
      end
   endtask

   task automatic send_cmd(input logic op, input logic [CoordBits-1:0] xb, yb, xf, yf,
                           input logic [ColorBits-1:0] rgb);
      send_word('{op: op, x_begin: xb, y_begin: yb, x_finish: xf, y_finish: yf,
                  color_rgb: rgb});
   endtask

   // step words carry random junk in the unused fields
   task automatic send_steps(input int n);
      repeat (n) send_cmd(OpStep, CoordBits'($urandom), CoordBits'($urandom),
                          CoordBits'($urandom), CoordBits'($urandom),
                          ColorBits'($urandom));
   endtask

   // drain: nothing owed, then enough cycles for starts still in the pipe
   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (walker.pending() != 0);
      repeat (10) @(posedge clock);
   endtask

   // half fully random, half close to the clip edge
   function automatic logic [CoordBits-1:0] near_bound(input logic [DimBits-1:0] bound);
      int v;
      if ($urandom_range(0, 1) == 0) return CoordBits'($urandom);
      v = int'(bound) + int'($urandom_range(0, 16)) - 8;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[CoordBits-1:0];
   endfunction

   function automatic logic [CoordBits-1:0] reach(input logic [CoordBits-1:0] from,
                                                  input int d);
      if ($urandom_range(0, 1) == 1 && int'(from) + d <= 65535)
         return CoordBits'(int'(from) + d);
      if (int'(from) >= d) return CoordBits'(int'(from) - d);
      return CoordBits'(int'(from) + d);
   endfunction

   function automatic int walk_length(input line_cmd_type w);
      int ax;
      int ay;
      ax = int'(w.x_finish) - int'(w.x_begin);
      ay = int'(w.y_finish) - int'(w.y_begin);
      if (ax < 0) ax = -ax;
      if (ay < 0) ay = -ay;
      return ((ax > ay) ? ax : ay) + 1;
   endfunction

   function automatic screen_setup_type pick_setup(input setup_style_type style);
      screen_setup_type s;
      s.base = AddrBits'({$urandom, $urandom});
      s.width = ($urandom_range(0, 2) == 0) ? DimBits'($urandom_range(1, 300))
                                             : DimBits'($urandom);
      s.height = ($urandom_range(0, 2) == 0) ? DimBits'($urandom_range(1, 300))
                                              : DimBits'($urandom);
      s.pitch = PitchBits'($urandom);
      s.red_sh = ShiftBits'($urandom_range(0, 31));
      s.green_sh = ShiftBits'($urandom_range(0, 31));
      s.blue_sh = ShiftBits'($urandom_range(0, 31));
      s.on = ($urandom_range(0, 7) != 0);
      if (style == SetupTop) begin
         s.base = '1;
         s.width = '1;
         s.height = '1;
         s.pitch = '1;
         s.red_sh = '1;
         s.green_sh = '1;
         s.blue_sh = '1;
         s.on = 1'b1;
      end else if (style == SetupFloor) begin
         s.base = '0;
         s.width = '0;
         s.height = '0;
         s.pitch = '0;
         s.red_sh = '0;
         s.green_sh = '0;
         s.blue_sh = '0;
         s.on = 1'b1;
      end
      return s;
   endfunction

   // a start and its steps: mostly run to the end, some cut short, some overrun
   task automatic draw_line(input int span, inout int counted);
      line_cmd_type w;
      int           steps;
      int           r;
      w.op = OpStart;
      w.x_begin = near_bound(active_setup.width);
      w.y_begin = near_bound(active_setup.height);
      w.x_finish = reach(w.x_begin, $urandom_range(0, span));
      w.y_finish = reach(w.y_begin, $urandom_range(0, span));
      w.color_rgb = ColorBits'($urandom);
      send_word(w);
      steps = walk_length(w);
      r = $urandom_range(0, 19);
      if (r < 3) steps = $urandom_range(0, steps - 1);
      else if (r < 5) steps += $urandom_range(1, 3);
      send_steps(steps);
      counted += steps + 1;
   endtask

   task automatic run_random_phase(input int quota);
      int counted;
      int r;
      int span;
      int n;
      counted = 0;
      while (counted < quota) begin
         r = $urandom_range(0, 99);
         if (r < 78) begin
            n = $urandom_range(0, 99);
            span = (n < 90) ? 12 : ((n < 99) ? 100 : 600);
            draw_line(span, counted);
         end else if (r < 90) begin
            // wholly random start, usually dropped by the next one
            send_cmd(OpStart, CoordBits'($urandom), CoordBits'($urandom),
                     CoordBits'($urandom), CoordBits'($urandom), ColorBits'($urandom));
            n = $urandom_range(0, 6);
            send_steps(n);
            counted += n + 1;
         end else begin
            send_steps($urandom_range(1, 3));
         end
      end
   endtask

   // main sequence
   initial begin
      screen_setup_type s;
      int               quota;
      setup_style_type  style;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = CsrBaseAddress;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.op = OpStart;
      req_bus.x_begin = '0;
      req_bus.y_begin = '0;
      req_bus.x_finish = '0;
      req_bus.y_finish = '0;
      req_bus.color_rgb = '0;
      rsp_bus.ready = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // registers at reset: start dropped, step finds the engine idle
      send_cmd(OpStart, 16'd1, 16'd2, 16'd3, 16'd4, 24'h0a0b0c);
      send_steps(1);
      settle();

      // small screen: single point, clipped shallow line, restart mid-line
      s = '{base: 48'h1000, width: 16'd64, height: 16'd48, pitch: 18'd256,
            red_sh: 5'd16, green_sh: 5'd8, blue_sh: 5'd0, on: 1'b1};
      load_setup(s);
      send_cmd(OpStart, 16'd5, 16'd5, 16'd5, 16'd5, 24'h123456);
      send_steps(2);
      send_cmd(OpStart, 16'd60, 16'd40, 16'd70, 16'd44, 24'hff00ff);
      send_steps(11);
      send_cmd(OpStart, 16'd0, 16'd0, 16'd3, 16'd3, 24'h00ff00);
      send_steps(1);
      send_cmd(OpStart, 16'hffff, 16'hffff, 16'hfffd, 16'hfffe, 24'hffffff);
      send_steps(3);
      settle();

      // everything at its top value; address wraps, colour bits fall off
      s = pick_setup(SetupTop);
      load_setup(s);
      send_cmd(OpStart, 16'd0, 16'hffff, 16'd1, 16'hfffd, 24'hffffff);
      send_steps(1);
      settle();

      // display dropped mid-line: walk continues with writes off
      s = '{base: '0, width: '1, height: '1, pitch: '0,
            red_sh: '0, green_sh: '0, blue_sh: '0, on: 1'b0};
      load_setup(s);
      send_steps(2);
      send_cmd(OpStart, 16'd9, 16'd9, 16'd12, 16'd12, 24'h445566);
      send_steps(1);
      settle();

      // random phases, each with fresh register values
      for (int p = 0; p < 10; p++) begin
         style = (p == 0) ? SetupTop : ((p == 5) ? SetupFloor : SetupRandom);
         s = pick_setup(style);
         if (p == 3) s.on = 1'b1;
         load_setup(s);
         if (p == 3) hold_request = 1'b1;
         quota = s.on ? 140 : 30;
         run_random_phase(quota);
         settle();
      end

      $display("covered %0d lines loaded, %0d starts dropped, %0d steps while idle",
               walker.lines_loaded, walker.starts_dropped, walker.idle_steps);
      $display("checked %0d pixels: %0d with writes off, %0d line ends, %0d errors",
               walker.pixels_seen, walker.clipped_seen, walker.ends_seen, walker.errors);
      if (walker.errors == 0 && walker.pending() == 0) begin
         $display("clipped_line_pixel_generator_core_tb: PASS");
      end else begin
         $display("clipped_line_pixel_generator_core_tb: FAIL");
      end
      $finish;
   end

endmodule

/* clipped_line_pixel_generator_core.f */
hw/rtl/clpg_pkg.sv
hw/rtl/clpg_req_if.sv
hw/rtl/clpg_rsp_if.sv
hw/rtl/clpg_front.sv
hw/rtl/clpg_walker.sv
hw/rtl/clpg_addr.sv
hw/rtl/clipped_line_pixel_generator_core.sv
tb/clipped_line_pixel_generator_core_tb.sv
